[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the tiered timestamp ring database.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/ttdb_pkg.sv]
// Shared types and constants for the tiered timestamp ring database.
// No dependencies.
package ttdb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RINGS      = 3;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W     = $clog2(RINGS * RING_DEPTH);
  localparam int STAMP_W    = 63;
  localparam int TXG_W      = 64;
  localparam int GAP_W      = 32;
  localparam int ENTRY_W    = STAMP_W + TXG_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAP_W-1:0] MONTH_GAP_RESET = GAP_W'(30 * 24 * 60 * 60);
  localparam logic [GAP_W-1:0] DAY_GAP_RESET   = GAP_W'(24 * 60 * 60);

  localparam logic [CFG_IDX_W-1:0] REG_MONTH_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_GAP   = 1'b1;

  localparam logic [1:0] MINUTE_RING = 2'd0;
  localparam logic [1:0] DAY_RING    = 2'd1;
  localparam logic [1:0] MONTH_RING  = 2'd2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_TEST,
    ST_WRITE,
    ST_SCAN_START,
    ST_SCAN,
    ST_MERGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TXG_W-1:0] txg;
    logic             found;
  } res_t;

endpackage

[hw/rtl/ttdb_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ttdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ttdb_ctrl.sv]
// Sequencer and shared datapath: add placement, ring writes, query scan/merge.
// Depends on ttdb_pkg, ttdb_ram and assert_macros.svh.
`include "assert_macros.svh"

module ttdb_ctrl
  import ttdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [TXG_W-1:0]   in_txg_in,
  input  logic               in_rounding,
  input  logic [GAP_W-1:0]   month_gap,
  input  logic [GAP_W-1:0]   day_gap,
  output res_t               res,
  input  logic               res_ready
);

  state_t state_r, state_nxt;

  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [TXG_W-1:0]   txg_r, txg_nxt;
  logic               ceil_r, ceil_nxt;
  logic [1:0]         ring_r, ring_nxt;

  logic [PTR_W-1:0]   oldest_r [RINGS];
  logic [PTR_W-1:0]   oldest_nxt [RINGS];
  logic [PTR_W-1:0]   next_r [RINGS];
  logic [PTR_W-1:0]   next_nxt [RINGS];
  logic [PTR_W-1:0]   newest_r [RINGS];
  logic [PTR_W-1:0]   newest_nxt [RINGS];
  logic [CNT_W-1:0]   fill_r [RINGS];
  logic [CNT_W-1:0]   fill_nxt [RINGS];
  logic [STAMP_W-1:0] ntime_r [RINGS];
  logic [STAMP_W-1:0] ntime_nxt [RINGS];
  logic [TXG_W-1:0]   ntxg_r [RINGS];
  logic [TXG_W-1:0]   ntxg_nxt [RINGS];

  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   issued_r, issued_nxt;
  logic               dvld_r, dvld_nxt;
  logic               cand_ok_r, cand_ok_nxt;
  logic [STAMP_W-1:0] cand_time_r, cand_time_nxt;
  logic [TXG_W-1:0]   cand_txg_r, cand_txg_nxt;
  logic               best_ok_r, best_ok_nxt;
  logic [STAMP_W-1:0] best_dist_r, best_dist_nxt;
  logic [TXG_W-1:0]   best_txg_r, best_txg_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [STAMP_W-1:0] rd_time;
  logic [TXG_W-1:0]   rd_txg;

  logic [ADDR_W-1:0]  ring_base;
  logic [CNT_W-1:0]   cur_fill;
  logic [STAMP_W-1:0] cur_ntime;
  logic [GAP_W-1:0]   cur_gap;
  logic [STAMP_W:0]   diff;
  logic               gap_ok;
  logic [STAMP_W-1:0] span;
  logic               take;
  logic               stop;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  ttdb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RINGS * RING_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_time   = ram_rdata[ENTRY_W-1:TXG_W];
  assign rd_txg    = ram_rdata[TXG_W-1:0];
  assign ring_base = ADDR_W'(ring_r) * ADDR_W'(RING_DEPTH);
  assign cur_fill  = fill_r[ring_r];
  // empty ring counts as newest time zero
  assign cur_ntime = (cur_fill == '0) ? '0 : ntime_r[ring_r];

  always_comb begin
    case (ring_r)
      MONTH_RING: cur_gap = month_gap;
      DAY_RING:   cur_gap = day_gap;
      default:    cur_gap = '0;
    endcase
  end

  // shared subtract/compare unit
  assign diff   = {1'b0, stamp_r} - {1'b0, cur_ntime};
  assign gap_ok = !diff[STAMP_W] && (diff[STAMP_W-1:0] >= STAMP_W'(cur_gap));
  assign span   = (stamp_r >= cand_time_r) ? stamp_r - cand_time_r : cand_time_r - stamp_r;

  always_comb begin
    // day wins only strictly closer; month wins on a tie
    case (ring_r)
      DAY_RING:   take = span < best_dist_r;
      MONTH_RING: take = span <= best_dist_r;
      default:    take = 1'b1;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    stamp_nxt     = stamp_r;
    txg_nxt       = txg_r;
    ceil_nxt      = ceil_r;
    ring_nxt      = ring_r;
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    newest_nxt    = newest_r;
    fill_nxt      = fill_r;
    ntime_nxt     = ntime_r;
    ntxg_nxt      = ntxg_r;
    ptr_nxt       = ptr_r;
    issued_nxt    = issued_r;
    dvld_nxt      = 1'b0;
    cand_ok_nxt   = cand_ok_r;
    cand_time_nxt = cand_time_r;
    cand_txg_nxt  = cand_txg_r;
    best_ok_nxt   = best_ok_r;
    best_dist_nxt = best_dist_r;
    best_txg_nxt  = best_txg_r;
    ram_we        = 1'b0;
    ram_waddr     = ring_base + ADDR_W'(next_r[ring_r]);
    ram_wdata     = {stamp_r, txg_r};
    ram_raddr     = ring_base + ADDR_W'(ptr_r);
    stop          = 1'b0;
    res.valid     = 1'b0;
    res.txg       = best_ok_r ? best_txg_r : '0;
    res.found     = best_ok_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          stamp_nxt = in_stamp;
          txg_nxt   = in_txg_in;
          ceil_nxt  = in_rounding;
          if (in_op == OP_ADD) begin
            ring_nxt  = MONTH_RING;
            state_nxt = ST_ADD_TEST;
          end else begin
            ring_nxt    = MINUTE_RING;
            best_ok_nxt = 1'b0;
            state_nxt   = ST_SCAN_START;
          end
        end
      end
      ST_ADD_TEST: begin
        if (gap_ok) begin
          state_nxt = ST_WRITE;
        end else if (ring_r == MINUTE_RING) begin
          state_nxt = ST_IDLE;   // older than the minute ring: dropped
        end else begin
          ring_nxt = ring_r - 1'b1;
        end
      end
      ST_WRITE: begin
        if (cur_fill != '0 && ntime_r[ring_r] == stamp_r) begin
          // same second as newest entry: raise txg in place
          if (ntxg_r[ring_r] < txg_r) begin
            ram_we            = 1'b1;
            ram_waddr         = ring_base + ADDR_W'(newest_r[ring_r]);
            ntxg_nxt[ring_r]  = txg_r;
          end
        end else begin
          ram_we             = 1'b1;
          newest_nxt[ring_r] = next_r[ring_r];
          next_nxt[ring_r]   = wrap_inc(next_r[ring_r]);
          ntime_nxt[ring_r]  = stamp_r;
          ntxg_nxt[ring_r]   = txg_r;
          if (cur_fill < CNT_W'(RING_DEPTH)) begin
            fill_nxt[ring_r] = cur_fill + 1'b1;
          end else begin
            oldest_nxt[ring_r] = wrap_inc(oldest_r[ring_r]);
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN_START: begin
        ptr_nxt     = oldest_r[ring_r];
        issued_nxt  = '0;
        cand_ok_nxt = 1'b0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        // evaluate the entry read last cycle
        if (dvld_r) begin
          if (!ceil_r) begin
            if (stamp_r < rd_time) begin
              stop = 1'b1;
            end else begin
              cand_ok_nxt   = 1'b1;
              cand_time_nxt = rd_time;
              cand_txg_nxt  = rd_txg;
            end
          end else if (stamp_r <= rd_time) begin
            cand_ok_nxt   = 1'b1;
            cand_time_nxt = rd_time;
            cand_txg_nxt  = rd_txg;
            stop          = 1'b1;
          end
        end
        // issue the next read
        if (issued_r < cur_fill) begin
          ptr_nxt    = wrap_inc(ptr_r);
          issued_nxt = issued_r + 1'b1;
          dvld_nxt   = 1'b1;
        end
        if (stop || (!dvld_r && issued_r == cur_fill)) begin
          dvld_nxt  = 1'b0;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (cand_ok_r && (!best_ok_r || take)) begin
          best_ok_nxt   = 1'b1;
          best_dist_nxt = span;
          best_txg_nxt  = cand_txg_r;
        end
        if (ring_r == MONTH_RING) begin
          state_nxt = ST_DONE;
        end else begin
          ring_nxt  = ring_r + 1'b1;
          state_nxt = ST_SCAN_START;
        end
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dvld_r  <= 1'b0;
      for (int i = 0; i < RINGS; i++) begin
        oldest_r[i] <= '0;
        next_r[i]   <= '0;
        fill_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      dvld_r   <= dvld_nxt;
      oldest_r <= oldest_nxt;
      next_r   <= next_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r     <= stamp_nxt;
    txg_r       <= txg_nxt;
    ceil_r      <= ceil_nxt;
    ring_r      <= ring_nxt;
    newest_r    <= newest_nxt;
    ntime_r     <= ntime_nxt;
    ntxg_r      <= ntxg_nxt;
    ptr_r       <= ptr_nxt;
    issued_r    <= issued_nxt;
    cand_ok_r   <= cand_ok_nxt;
    cand_time_r <= cand_time_nxt;
    cand_txg_r  <= cand_txg_nxt;
    best_ok_r   <= best_ok_nxt;
    best_dist_r <= best_dist_nxt;
    best_txg_r  <= best_txg_nxt;
  end

  `ASSERT_CLK(a_we_only_in_write, ram_we |-> state_r == ST_WRITE, "store written outside write")
  `ASSERT_NEVER(a_fill_bound, fill_r[0] > CNT_W'(RING_DEPTH) || fill_r[1] > CNT_W'(RING_DEPTH) || fill_r[2] > CNT_W'(RING_DEPTH), "ring fill above depth")
  `ASSERT_CLK(a_scan_bound, state_r == ST_SCAN |-> issued_r <= cur_fill, "scan read past fill")

endmodule

[hw/rtl/tiered_timestamp_ring_db_unit.sv]
// Top level of the tiered timestamp ring database: config registers, result register.
// Depends on ttdb_pkg and ttdb_ctrl.

// Three overwrite-oldest rings (minute, day, month) of RING_DEPTH (time, txg)
// entries each, held in one shared RAM. An add item runs the placement test
// through one subtract/compare unit, walking month, day, minute rings (an add
// older than the minute ring's newest is dropped), then writes the entry (or
// raises the newest txg in place when the time matches). A query item scans
// the rings one after another through the single RAM read port, one entry per
// cycle, stopping early when the floor/ceiling is settled. Nearest candidate
// wins; ties prefer minute over day, month over both. in_ready is high only
// between items. The result sits in an output register, so a finished query
// waits there for out_ready while the next item is taken in. cfg_index 0 is
// month_gap, 1 is day_gap; write only while idle.
module tiered_timestamp_ring_db_unit
  import ttdb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [STAMP_W-1:0]   in_stamp,
  input  logic [TXG_W-1:0]     in_txg_in,
  input  logic                 in_rounding,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TXG_W-1:0]     out_txg_out,
  output logic                 out_found,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAP_W-1:0]     cfg_wdata
);

  logic [GAP_W-1:0] month_gap_r, day_gap_r;
  logic             out_valid_r;
  logic [TXG_W-1:0] out_txg_r;
  logic             out_found_r;
  res_t             res;
  logic             res_ready;

  // result slot free, or being emptied this cycle
  assign res_ready = !out_valid_r || out_ready;

  ttdb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_stamp   (in_stamp),
    .in_txg_in  (in_txg_in),
    .in_rounding(in_rounding),
    .month_gap  (month_gap_r),
    .day_gap    (day_gap_r),
    .res        (res),
    .res_ready  (res_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_gap_r <= MONTH_GAP_RESET;
      day_gap_r   <= DAY_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MONTH_GAP: month_gap_r <= cfg_wdata;
        REG_DAY_GAP:   day_gap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_txg_r   <= res.txg;
      out_found_r <= res.found;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_txg_out = out_txg_r;
  assign out_found   = out_found_r;

endmodule

[dv/tb.sv]
// Testbench for tiered_timestamp_ring_db_unit: directed and random add/query items,
// checked against a behavioral model of the three rings kept inside this bench.
// Depends on ttdb_pkg and the RTL of the unit.
module tb;
  import ttdb_pkg::*;

  typedef struct {
    logic [TXG_W-1:0] txg;
    logic             found;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_ADD;
  logic [STAMP_W-1:0] in_stamp = '0;
  logic [TXG_W-1:0]   in_txg_in = '0;
  logic               in_rounding = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TXG_W-1:0]   out_txg_out;
  logic               out_found;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MONTH_GAP;
  logic [GAP_W-1:0]   cfg_wdata = '0;

  tiered_timestamp_ring_db_unit DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the rings and the gap registers.
  logic [63:0]    ring_time [RINGS][RING_DEPTH];
  logic [TXG_W-1:0] ring_txg [RINGS][RING_DEPTH];
  int unsigned    ring_head [RINGS];
  int unsigned    ring_tail [RINGS];
  int unsigned    ring_fill [RINGS];
  logic [63:0]    month_gap_q = 64'(MONTH_GAP_RESET);
  logic [63:0]    day_gap_q   = 64'(DAY_GAP_RESET);

  lookup_t        pending_lookups[$];
  int             mismatches = 0;
  int             cycles = 0;
  bit             idle_on = 1'b1;   // random idling on both channels
  logic [62:0]    now_s;            // running wall time for well-formed add sequences

  function automatic logic [63:0] newest_time(int r);
    int unsigned n;
    if (ring_fill[r] == 0) return 64'd0;
    n = (ring_tail[r] == 0) ? RING_DEPTH - 1 : ring_tail[r] - 1;
    return ring_time[r][n];
  endfunction

  function automatic void ring_store(int r, logic [63:0] t, logic [TXG_W-1:0] txg);
    int unsigned n;
    if (ring_fill[r] != 0) begin
      n = (ring_tail[r] == 0) ? RING_DEPTH - 1 : ring_tail[r] - 1;
      // same time as newest: raise txg in place, never append
      if (ring_time[r][n] == t) begin
        if (ring_txg[r][n] < txg) ring_txg[r][n] = txg;
        return;
      end
    end
    ring_time[r][ring_tail[r]] = t;
    ring_txg[r][ring_tail[r]] = txg;
    ring_tail[r] = (ring_tail[r] + 1) % RING_DEPTH;
    if (ring_fill[r] < RING_DEPTH) ring_fill[r]++;
    else ring_head[r] = (ring_head[r] + 1) % RING_DEPTH;
  endfunction

  function automatic void place_record(logic [62:0] stamp, logic [TXG_W-1:0] txg);
    logic [63:0] s, tm, td, tn;
    s  = {1'b0, stamp};
    tm = newest_time(int'(MONTH_RING));
    td = newest_time(int'(DAY_RING));
    tn = newest_time(int'(MINUTE_RING));
    if (s >= tm && s - tm >= month_gap_q) ring_store(int'(MONTH_RING), s, txg);
    else if (s >= td && s - td >= day_gap_q) ring_store(int'(DAY_RING), s, txg);
    else if (s >= tn) ring_store(int'(MINUTE_RING), s, txg);
  endfunction

  // Floor or ceiling candidate of one ring; returns -1 when none.
  function automatic int ring_pick(int r, logic [63:0] tv, logic ceil);
    int pick;
    int unsigned n;
    pick = -1;
    for (int unsigned i = 0; i < ring_fill[r]; i++) begin
      n = (ring_head[r] + i) % RING_DEPTH;
      if (!ceil) begin
        if (tv < ring_time[r][n]) break;
        pick = n;
      end else if (tv <= ring_time[r][n]) begin
        pick = n;
        break;
      end
    end
    return pick;
  endfunction

  function automatic logic [63:0] gap_of(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic lookup_t nearest_txg(logic [62:0] stamp, logic ceil);
    lookup_t res;
    logic [63:0] tv;
    int p_min, p_day, p_mon, w_ring, w_slot;
    tv = {1'b0, stamp};
    p_min = ring_pick(int'(MINUTE_RING), tv, ceil);
    p_day = ring_pick(int'(DAY_RING), tv, ceil);
    p_mon = ring_pick(int'(MONTH_RING), tv, ceil);
    w_ring = -1;
    w_slot = -1;
    // minute wins ties against day
    if (p_min >= 0) begin w_ring = int'(MINUTE_RING); w_slot = p_min; end
    if (p_day >= 0) begin
      if (w_ring < 0 || gap_of(tv, ring_time[int'(DAY_RING)][p_day]) <
          gap_of(tv, ring_time[w_ring][w_slot])) begin
        w_ring = int'(DAY_RING); w_slot = p_day;
      end
    end
    // month wins ties against both
    if (p_mon >= 0) begin
      if (w_ring < 0 || !(gap_of(tv, ring_time[w_ring][w_slot]) <
          gap_of(tv, ring_time[int'(MONTH_RING)][p_mon]))) begin
        w_ring = int'(MONTH_RING); w_slot = p_mon;
      end
    end
    res.found = (w_ring >= 0);
    res.txg = res.found ? ring_txg[w_ring][w_slot] : '0;
    return res;
  endfunction

  // Sends one item; the payload stays put until accepted.
  task automatic send_item(logic op, logic [62:0] stamp, logic [63:0] txg, logic rnd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_stamp    <= stamp;
    in_txg_in   <= txg;
    in_rounding <= rnd;
    do @(posedge clk); while (!in_ready);
    if (op == OP_ADD) place_record(stamp, txg);
    else pending_lookups.push_back(nearest_txg(stamp, rnd));
    @(negedge clk);
  endtask

  task automatic add_rec(logic [62:0] stamp, logic [63:0] txg);
    send_item(OP_ADD, stamp, txg, 1'($urandom_range(0, 1)));
  endtask

  task automatic query_at(logic [62:0] stamp, logic rnd);
    send_item(OP_QUERY, stamp, {$urandom, $urandom}, rnd);
  endtask

  // Drain: no item in flight, all lookups answered, add write-back settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (!(in_ready && pending_lookups.size() == 0));
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gaps(logic [GAP_W-1:0] mgap, logic [GAP_W-1:0] dgap);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_MONTH_GAP; cfg_wdata <= mgap;
    @(negedge clk);
    cfg_index <= REG_DAY_GAP; cfg_wdata <= dgap;
    @(negedge clk);
    cfg_we <= 1'b0;
    month_gap_q = 64'(mgap);
    day_gap_q = 64'(dgap);
  endtask

  // Random add: mostly forward in time, some equal and stale stamps.
  task automatic random_add(int step);
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) now_s = now_s + 63'($urandom_range(0, step));
    if (k >= 85 && now_s > 63'(step)) add_rec(now_s - 63'($urandom_range(1, step)), {$urandom, $urandom});
    else add_rec(now_s, (k % 7 == 0) ? 64'($urandom_range(0, 3)) : {$urandom, $urandom});
  endtask

  task automatic random_query(int step);
    if ($urandom_range(0, 9) == 0) query_at(63'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    else query_at(now_s - 63'($urandom_range(0, step * 300)) + 63'($urandom_range(0, step)),
                  1'($urandom_range(0, 1)));
  endtask

  task automatic random_mix(int n, int step, int query_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < query_pct) random_query(step);
      else random_add(step);
    end
  endtask

  // Empty rings, equal-time raise, drops, tier placement and tie breaks.
  task automatic test_directed();
    query_at(63'd0, 1'b0);
    query_at('1, 1'b1);
    add_rec(63'd0, 64'd5);                 // minute ring, time 0
    add_rec(63'd0, 64'd3);                 // equal time, smaller txg: ignored
    add_rec(63'd0, '1);                    // equal time, larger txg: raised
    add_rec(63'd100, 64'd7);
    add_rec(63'd50, 64'd9);                // older than minute newest: dropped
    add_rec(63'd86400, 64'd11);            // day ring
    add_rec(63'd2592000, 64'd13);          // month ring
    add_rec(63'd2592000, 64'd2);           // equal to month newest: goes to day ring
    query_at(63'd0, 1'b0);
    query_at(63'd99, 1'b1);
    query_at(63'd50, 1'b0);
    query_at(63'd43250, 1'b0);             // midway minute 100/day 86400; floor picks minute
    query_at(63'd1339200, 1'b1);           // equal distance day/month
    query_at(63'd2592001, 1'b1);           // nothing at or after
    query_at('1, 1'b0);
    add_rec(63'd2592100, 64'hAAAA_5555_0F0F_F0F0);
    query_at(63'd2592050, 1'b0);
    query_at(63'd2592050, 1'b1);
  endtask

  // Walk through gap settings including extremes and zero gap.
  task automatic test_gap_settings();
    write_gaps(32'd1000, 32'd50);
    random_mix(100, 40, 25);
    write_gaps('1, '1);                    // only the minute ring takes adds
    random_mix(80, 500, 20);
    write_gaps(32'd1, 32'd1);              // nearly everything to month
    random_mix(80, 3, 20);
    write_gaps(32'd0, 32'd0);
    random_mix(50, 3, 25);
    write_gaps('1, 32'd1);
    random_mix(70, 5, 20);
  endtask

  // Overfill the month and minute rings so the oldest entries get overwritten.
  task automatic test_ring_wrap();
    write_gaps(32'd1, 32'd1);
    for (int i = 0; i < 260; i++) add_rec(now_s + 63'(i + 1), {$urandom, $urandom});
    now_s = now_s + 63'd261;
    repeat (10) random_query(5);
    write_gaps('1, '1);
    for (int i = 0; i < 260; i++) add_rec(now_s + 63'(2 * i), {$urandom, $urandom});
    now_s = now_s + 63'd520;
    repeat (10) random_query(5);
  endtask

  task automatic test_random_bulk();
    write_gaps(32'($urandom_range(100, 5000)), 32'($urandom_range(5, 200)));
    random_mix(150, 60, 30);
    write_gaps(MONTH_GAP_RESET, DAY_GAP_RESET);
    random_mix(80, 20000, 30);
  endtask

  // Last stretch with no idling on either side, then huge stamps.
  task automatic test_full_rate();
    idle_on = 1'b0;
    random_mix(100, 60, 30);
    now_s = 63'h7FFF_FFFF_FFFF_FF00;
    random_mix(20, 10, 40);
    add_rec('1, '1);
    query_at('1, 1'b0);
    query_at('1, 1'b1);
  endtask

  // Result stall bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result txg=%h found=%b", out_txg_out, out_found);
      end else begin
        lookup_t want;
        want = pending_lookups.pop_front();
        if (want.txg !== out_txg_out || want.found !== out_found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lookup mismatch: want txg=%h found=%b, got txg=%h found=%b",
                     want.txg, want.found, out_txg_out, out_found);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < RINGS; r++) begin
      ring_head[r] = 0; ring_tail[r] = 0; ring_fill[r] = 0;
    end
    now_s = 63'd3000000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_gap_settings();
    test_ring_wrap();
    test_random_bulk();
    test_full_rate();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ttdb_pkg.sv
hw/rtl/ttdb_ram.sv
hw/rtl/ttdb_ctrl.sv
hw/rtl/tiered_timestamp_ring_db_unit.sv
dv/tb.sv
